@@ rtl/oofr_pkg.sv @@
// Shared constants and types for the oversampled optical frame receiver.
package oofr_pkg;

    // Default framing parameters
    localparam int SAMPLES_PER_BIT_DEF = 5;
    localparam int DATA_BITS_DEF       = 4;
    localparam int PREAMBLE_ONES_DEF   = 3;

    // Sample and bus widths
    localparam int SAMPLE_W   = 10;
    localparam int IN_TDATA_W = 16;

    // One thresholded sample handed to the framing core
    typedef struct packed {
        logic step;        // a registered sample is processed this cycle
        logic sample_bit;  // sample read as a one (at or below threshold)
    } oofr_sample_t;

endpackage

@@ rtl/oversampled_optical_frame_receiver.sv @@
// Top level of the oversampled optical frame receiver.
// Usage:
//   s_axis carries one light sensor sample per item (tdata[9:0] adc_sample).
//   A sample at or below the threshold register reads as a one. Five samples
//   form one bit window; the receiver realigns its windows, hunts for three or
//   more ones followed by a zero, skips one bit period and then collects four
//   data bits, which leave on m_axis as one item (tdata[3:0] data_word).
//   cfg_valid/cfg_data write the 10-bit threshold; write it only while idle.
// Throughput:
//   One sample item per cycle is accepted while m_axis is not stalled. A
//   sample is thresholded into an input register and then processed by the
//   framing core from that register; its word (if any) is held in an output
//   register that drives m_axis.
// Reset:
//   rst_n clears the threshold to zero, the window state, the preamble hunt
//   and the data collection; no output is pending after reset.
// Stall:
//   While m_axis holds an untaken word, the input register stops advancing
//   and s_axis_tready drops once that register is full.
module oversampled_optical_frame_receiver #(
    parameter int SAMPLES_PER_BIT = oofr_pkg::SAMPLES_PER_BIT_DEF,
    parameter int DATA_BITS       = oofr_pkg::DATA_BITS_DEF,
    parameter int PREAMBLE_ONES   = oofr_pkg::PREAMBLE_ONES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // config write: threshold
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [oofr_pkg::SAMPLE_W-1:0]        cfg_data,
    // sample stream; tdata: [9:0] adc_sample, rest zero
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [oofr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // word stream; tdata: [DATA_BITS-1:0] data_word, rest zero
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((DATA_BITS+7)/8)*8-1:0]       m_axis_tdata
);
    import oofr_pkg::*;

    localparam int OUT_TDATA_W = ((DATA_BITS + 7) / 8) * 8;

    logic [SAMPLE_W-1:0]  thresh_reg;
    logic                 in_valid_reg;
    logic                 in_bit_reg;
    logic                 out_valid_reg;
    logic [DATA_BITS-1:0] out_word_reg;
    logic                 advance;
    oofr_sample_t         smp;
    logic                 word_valid;
    logic [DATA_BITS-1:0] word;

    // Threshold register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= '0;
        else if (cfg_valid && cfg_ready)
            thresh_reg <= cfg_data;
    end

    // Input register: holds the thresholded sample
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_bit_reg <= (s_axis_tdata[SAMPLE_W-1:0] <= thresh_reg);
    end

    // Framing core
    assign smp.step       = in_valid_reg && advance;
    assign smp.sample_bit = in_bit_reg;

    oofr_core #(
        .SAMPLES_PER_BIT (SAMPLES_PER_BIT),
        .DATA_BITS       (DATA_BITS),
        .PREAMBLE_ONES   (PREAMBLE_ONES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .smp        (smp),
        .word_valid (word_valid),
        .word       (word)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (smp.step)
            out_valid_reg <= word_valid;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (smp.step && word_valid)
            out_word_reg <= word;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_word_reg);

    // Checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");

    a_word_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_valid_reg))
        else $error("word produced without a processed sample");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !s_axis_tready) |-> (out_valid_reg && !m_axis_tready))
        else $error("input stalled without output backpressure");

endmodule

@@ rtl/oofr_core.sv @@
// Bit window alignment, preamble hunt and data word assembly.
module oofr_core #(
    parameter int SAMPLES_PER_BIT = oofr_pkg::SAMPLES_PER_BIT_DEF,
    parameter int DATA_BITS       = oofr_pkg::DATA_BITS_DEF,
    parameter int PREAMBLE_ONES   = oofr_pkg::PREAMBLE_ONES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  oofr_pkg::oofr_sample_t smp,
    output logic                   word_valid,
    output logic [DATA_BITS-1:0]   word
);
    import oofr_pkg::*;

    localparam int ALLOWED = (SAMPLES_PER_BIT - 1) / 2;
    localparam int MID     = SAMPLES_PER_BIT / 2;
    localparam int IDX_W   = $clog2(SAMPLES_PER_BIT);
    localparam int SKIP_W  = $clog2(SAMPLES_PER_BIT + ALLOWED + 1);
    localparam int PRE_W   = $clog2(PREAMBLE_ONES + 1);
    localparam int CNT_W   = $clog2(DATA_BITS + 1);

    // Receive phase codes
    localparam logic PHASE_HUNT = 1'b0;
    localparam logic PHASE_DATA = 1'b1;

    logic [SAMPLES_PER_BIT-1:0] win_reg, win_next, win_full;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [SKIP_W-1:0]          skip_reg, skip_next;
    logic [PRE_W-1:0]           pre_reg, pre_next;
    logic                       phase_reg, phase_next;
    logic [DATA_BITS-1:0]       shift_reg, shift_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next, cnt_inc;
    logic [DATA_BITS:0]         shift_ins;
    logic                       win_done, cur_bit, enter_data;
    logic [IDX_W-1:0]           lead_k, trail_k;
    logic                       lead_run, trail_run;

    // Window with the current sample dropped in at its slot
    always_comb
    begin
        for (int i = 0; i < SAMPLES_PER_BIT; i++)
        begin
            win_full[i] = (idx_reg == IDX_W'(i)) ? smp.sample_bit : win_reg[i];
        end
    end

    assign win_done  = (idx_reg == IDX_W'(SAMPLES_PER_BIT - 1));
    assign cur_bit   = win_full[MID];
    assign shift_ins = {shift_reg, cur_bit};
    assign cnt_inc   = cnt_reg + CNT_W'(1);

    // Leading and trailing samples that disagree with the window's bit
    always_comb
    begin
        lead_k    = '0;
        trail_k   = '0;
        lead_run  = 1'b1;
        trail_run = 1'b1;
        for (int j = 0; j < ALLOWED; j++)
        begin
            if (lead_run && (win_full[j] != cur_bit))
                lead_k = lead_k + IDX_W'(1);
            else
                lead_run = 1'b0;
            if (trail_run && (win_full[SAMPLES_PER_BIT-1-j] != cur_bit))
                trail_k = trail_k + IDX_W'(1);
            else
                trail_run = 1'b0;
        end
    end

    // Next state for one processed sample
    always_comb
    begin
        win_next   = win_reg;
        idx_next   = idx_reg;
        skip_next  = skip_reg;
        pre_next   = pre_reg;
        phase_next = phase_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        enter_data = 1'b0;
        word_valid = 1'b0;
        word       = shift_ins[DATA_BITS-1:0];

        if (smp.step)
        begin
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - SKIP_W'(1);
            end
            else if (!win_done)
            begin
                win_next = win_full;
                idx_next = idx_reg + IDX_W'(1);
            end
            else
            begin
                // framing on the completed bit
                if (phase_reg == PHASE_HUNT)
                begin
                    if (cur_bit)
                    begin
                        if (pre_reg < PRE_W'(PREAMBLE_ONES))
                            pre_next = pre_reg + PRE_W'(1);
                    end
                    else if (pre_reg >= PRE_W'(PREAMBLE_ONES))
                    begin
                        phase_next = PHASE_DATA;
                        shift_next = '0;
                        cnt_next   = '0;
                        pre_next   = '0;
                        enter_data = 1'b1;
                    end
                    else
                    begin
                        pre_next = '0;
                    end
                end
                else
                begin
                    shift_next = shift_ins[DATA_BITS-1:0];
                    cnt_next   = cnt_inc;
                    if (cnt_inc >= CNT_W'(DATA_BITS))
                    begin
                        word_valid = 1'b1;
                        phase_next = PHASE_HUNT;
                        pre_next   = '0;
                        cnt_next   = '0;
                    end
                end

                // phase alignment of the next window
                win_next = win_full;
                if (win_full[0] != cur_bit)
                begin
                    idx_next  = '0;
                    skip_next = SKIP_W'(lead_k);
                end
                else
                begin
                    // reused trailing samples all read as the inverse bit
                    for (int i = 0; i < ALLOWED; i++)
                    begin
                        if (IDX_W'(i) < trail_k)
                            win_next[i] = ~cur_bit;
                    end
                    idx_next  = trail_k;
                    skip_next = '0;
                end
                if (enter_data)
                    skip_next = skip_next + SKIP_W'(SAMPLES_PER_BIT);
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            idx_reg   <= '0;
            skip_reg  <= '0;
            pre_reg   <= '0;
            phase_reg <= PHASE_HUNT;
            shift_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            win_reg   <= win_next;
            idx_reg   <= idx_next;
            skip_reg  <= skip_next;
            pre_reg   <= pre_next;
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
